FILE: rtl/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Shared constants for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_BITS_DEF = 32;

  // port widths of the result item
  localparam int AXIS_W  = 18;
  localparam int SHIFT_W = 32;

  // vectors are scaled so the largest magnitude sits in [2^29, 2^30)
  localparam int SCALE_W    = 30;
  localparam int SUMSQ_W    = 2 * SCALE_W + 2;
  localparam int ROOT_W     = SCALE_W + 1;
  localparam int ROOT_STEPS = 32;

endpackage

FILE: rtl/lav_scale.sv
// ----------------------------------------------------------------------------
// lav_scale
// Two-stage block scaler: finds the bit length of the largest magnitude of a
// 3-vector and shifts every component so that magnitude lands in [2^29, 2^30).
// ----------------------------------------------------------------------------
module lav_scale #(
  parameter int IW = 32,
  parameter int SW = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [IW-1:0]              src [3],
  input  logic        [SW-1:0]              side_in,
  output logic                              out_valid,
  output logic signed [lav_pkg::SCALE_W:0]  scaled [3],
  output logic        [SW-1:0]              side_out
);

  localparam int SCW = lav_pkg::SCALE_W;
  localparam int LW  = $clog2(IW + 1);
  localparam int XW  = IW + SCW;
  localparam logic [LW-1:0] TOP = LW'(SCW);

  logic [IW-1:0] mag_c [3];
  logic          neg_c [3];
  logic [IW-1:0] all_bits;
  logic [LW-1:0] len_c;

  logic          v1;
  logic [IW-1:0] mag1 [3];
  logic          neg1 [3];
  logic [LW-1:0] len1;
  logic [SW-1:0] side1;

  logic [XW-1:0]         wide_c [3];
  logic signed [SCW:0]   sc_c [3];

  logic                  v2;
  logic signed [SCW:0]   sc2 [3];
  logic [SW-1:0]         side2;

  always_comb begin
    all_bits = '0;
    for (int i = 0; i < 3; i++) begin
      neg_c[i] = src[i][IW-1];
      mag_c[i] = neg_c[i] ? $unsigned(-src[i]) : $unsigned(src[i]);
      all_bits = all_bits | mag_c[i];
    end
    // bit length of the OR equals bit length of the max
    len_c = '0;
    for (int k = 0; k < IW; k++) begin
      if (all_bits[k]) begin
        len_c = LW'(k + 1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (len1 > TOP) begin
        wide_c[i] = {{SCW{1'b0}}, mag1[i]} >> (len1 - TOP);
      end else begin
        wide_c[i] = {{SCW{1'b0}}, mag1[i]} << (TOP - len1);
      end
      sc_c[i] = neg1[i] ? -$signed({1'b0, wide_c[i][SCW-1:0]})
                        : $signed({1'b0, wide_c[i][SCW-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1  <= mag_c;
      neg1  <= neg_c;
      len1  <= len_c;
      side1 <= side_in;
      sc2   <= sc_c;
      side2 <= side1;
    end
  end

  assign out_valid = v2;
  assign scaled    = sc2;
  assign side_out  = side2;

endmodule

FILE: rtl/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: block scale, sum of squares, one root bit
// per stage, one quotient bit per stage. Side bits travel with each item.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int IW = 32,
  parameter int FB = 16,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [IW-1:0] src [3],
  input  logic        [SW-1:0] side_in,
  output logic                out_valid,
  output logic signed [FB+1:0] unit_vec [3],
  output logic        [SW-1:0] side_out
);

  localparam int SCW   = lav_pkg::SCALE_W;
  localparam int SQW   = lav_pkg::SUMSQ_W;
  localparam int XRW   = SQW + 1;
  localparam int RTW   = lav_pkg::ROOT_W;
  localparam int STEPS = lav_pkg::ROOT_STEPS;
  localparam int QW    = FB + 1;
  localparam int NW    = SCW + FB + 1;
  localparam int DRW   = RTW + 1;
  localparam int OW    = FB + 2;

  logic                sc_valid;
  logic signed [SCW:0] sc_vec [3];
  logic [SW-1:0]       sc_side;

  lav_scale #(
    .IW (IW),
    .SW (SW)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .src       (src),
    .side_in   (side_in),
    .out_valid (sc_valid),
    .scaled    (sc_vec),
    .side_out  (sc_side)
  );

  // squares
  logic [SCW-1:0]      am [3];
  logic [2*SCW-1:0]    sq_c [3];
  logic                v3;
  logic [2*SCW-1:0]    sq3 [3];
  logic signed [SCW:0] t3 [3];
  logic [SW-1:0]       side3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      am[i]   = sc_vec[i][SCW] ? SCW'(-sc_vec[i]) : sc_vec[i][SCW-1:0];
      sq_c[i] = am[i] * am[i];
    end
  end

  // root pipeline, index 0 holds the sum of squares
  logic [SQW-1:0]      rx [STEPS+1];
  logic [XRW-1:0]      rr [STEPS+1];
  logic signed [SCW:0] rt [STEPS+1][3];
  logic [SW-1:0]       rs [STEPS+1];
  logic                rv [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3    <= 1'b0;
      rv[0] <= 1'b0;
    end else if (en) begin
      v3    <= sc_valid;
      rv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq3   <= sq_c;
      t3    <= sc_vec;
      side3 <= sc_side;
      rx[0] <= SQW'(sq3[0]) + SQW'(sq3[1]) + SQW'(sq3[2]);
      rr[0] <= '0;
      rt[0] <= t3;
      rs[0] <= side3;
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_root
    localparam logic [XRW-1:0] BITV = XRW'(1) << (SQW - 2 * j);
    logic [XRW-1:0] rb;
    logic           ge;

    assign rb = rr[j] + BITV;
    assign ge = ({1'b0, rx[j]} >= rb);

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[j+1] <= 1'b0;
      end else if (en) begin
        rv[j+1] <= rv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx[j+1] <= ge ? SQW'({1'b0, rx[j]} - rb) : rx[j];
        rr[j+1] <= ge ? (rr[j] >> 1) + BITV : rr[j] >> 1;
        rt[j+1] <= rt[j];
        rs[j+1] <= rs[j];
      end
    end
  end

  // divider setup: numerator = mag * 2^FB + len/2, quotient fits FB+1 bits
  logic [RTW-1:0] root;
  logic [NW-1:0]  num_c [3];

  assign root = rr[STEPS][RTW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_c[i] = NW'({(rt[STEPS][i][SCW] ? SCW'(-rt[STEPS][i]) : rt[STEPS][i][SCW-1:0]),
                      {FB{1'b0}}}) + NW'(root >> 1);
    end
  end

  logic [DRW-1:0] drem [QW+1][3];
  logic [QW-1:0]  dn   [QW+1][3];
  logic [QW-1:0]  dq   [QW+1][3];
  logic           dneg [QW+1][3];
  logic [RTW-1:0] dlen [QW+1];
  logic [SW-1:0]  dside [QW+1];
  logic           dv   [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= rv[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= DRW'(num_c[i][NW-1:QW]);
        dn[0][i]   <= num_c[i][QW-1:0];
        dq[0][i]   <= '0;
        dneg[0][i] <= rt[STEPS][i][SCW];
      end
      dlen[0]  <= root;
      dside[0] <= rs[STEPS];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DRW-1:0] r2 [3];
    logic           ge [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i] = {drem[k][i][DRW-2:0], dn[k][i][QW-1]};
        ge[i] = (r2[i] >= {1'b0, dlen[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          drem[k+1][i] <= ge[i] ? r2[i] - {1'b0, dlen[k]} : r2[i];
          dn[k+1][i]   <= dn[k][i] << 1;
          dq[k+1][i]   <= {dq[k][i][QW-2:0], ge[i]};
          dneg[k+1][i] <= dneg[k][i];
        end
        dlen[k+1]  <= dlen[k];
        dside[k+1] <= dside[k];
      end
    end
  end

  // zero length means a zero vector: force the result to zero
  logic signed [OW-1:0] res_c [3];
  logic signed [OW-1:0] res [3];
  logic                 res_v;
  logic [SW-1:0]        res_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dlen[QW] == '0) begin
        res_c[i] = '0;
      end else if (dneg[QW][i]) begin
        res_c[i] = -$signed({1'b0, dq[QW][i]});
      end else begin
        res_c[i] = $signed({1'b0, dq[QW][i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (en) begin
      res_v <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res      <= res_c;
      res_side <= dside[QW];
    end
  end

  assign out_valid = res_v;
  assign unit_vec  = res;
  assign side_out  = res_side;

endmodule

FILE: rtl/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Throughput: one item per cycle, except while a full result register waits
// on out_ready; the two root/divide chains set the depth.
// A full result register with out_ready low freezes every stage at once.
// Reset (rst, synchronous) clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
  parameter int FRAC_BITS  = lav_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = lav_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_BITS-1:0]       target_x,
  input  logic signed [COORD_BITS-1:0]       target_y,
  input  logic signed [COORD_BITS-1:0]       target_z,
  input  logic signed [COORD_BITS-1:0]       eye_x,
  input  logic signed [COORD_BITS-1:0]       eye_y,
  input  logic signed [COORD_BITS-1:0]       eye_z,
  input  logic signed [COORD_BITS-1:0]       up_x,
  input  logic signed [COORD_BITS-1:0]       up_y,
  input  logic signed [COORD_BITS-1:0]       up_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [lav_pkg::AXIS_W-1:0]  side_x,
  output logic signed [lav_pkg::AXIS_W-1:0]  side_y,
  output logic signed [lav_pkg::AXIS_W-1:0]  side_z,
  output logic signed [lav_pkg::AXIS_W-1:0]  upward_x,
  output logic signed [lav_pkg::AXIS_W-1:0]  upward_y,
  output logic signed [lav_pkg::AXIS_W-1:0]  upward_z,
  output logic signed [lav_pkg::AXIS_W-1:0]  back_x,
  output logic signed [lav_pkg::AXIS_W-1:0]  back_y,
  output logic signed [lav_pkg::AXIS_W-1:0]  back_z,
  output logic signed [lav_pkg::SHIFT_W-1:0] shift_side,
  output logic signed [lav_pkg::SHIFT_W-1:0] shift_upward,
  output logic signed [lav_pkg::SHIFT_W-1:0] shift_back
);

  localparam int FB   = FRAC_BITS;
  localparam int CB   = COORD_BITS;
  localparam int AXW  = lav_pkg::AXIS_W;
  localparam int SHW  = lav_pkg::SHIFT_W;
  localparam int PRE  = (CB > 62) ? CB - 62 : 0;
  localparam int DW   = CB - PRE + 1;
  localparam int OW   = FB + 2;
  localparam int SCW  = lav_pkg::SCALE_W + 1;
  localparam int P1W  = OW + SCW;
  localparam int CW   = P1W + 1;
  localparam int P2W  = 2 * OW;
  localparam int AW   = P2W + 1;
  localparam int EH   = (CB > 32) ? CB - 32 : 1;
  localparam int LOW  = (CB > 32) ? 33 : CB;
  localparam int PLW  = OW + LOW;
  localparam int PHW  = OW + EH;
  localparam int TW   = (OW + CB + 3 > 34) ? OW + CB + 3 : 34;
  localparam int S1W  = 3 * DW + 3 * CB;
  localparam int S2W  = 3 * SCW + 3 * CB;
  localparam int S3W  = 3 * OW + 3 * CB;

  localparam logic signed [OW-1:0] UNIT_O = OW'(1) << FB;
  localparam logic signed [AW-1:0] HALF_A = AW'(1) << (FB - 1);
  localparam logic signed [AW-1:0] UNIT_A = AW'(1) << FB;
  localparam logic signed [TW-1:0] HALF_T = TW'(1) << (FB - 1);
  localparam logic signed [TW-1:0] SAT_HI = TW'(32'h7fff_ffff);
  localparam logic signed [TW-1:0] SAT_LO = -SAT_HI - TW'(1);

  logic adv;
  logic res_v;

  // whole pipeline moves unless a finished item is held at the output
  assign adv       = !res_v || out_ready;
  assign in_ready  = adv;
  assign out_valid = res_v;

  // ---- stage 0: direction target - eye
  logic signed [CB-1:0] tgt_in [3];
  logic signed [CB-1:0] eye_in [3];
  logic signed [CB-1:0] up_in  [3];
  logic signed [DW-1:0] d_c    [3];

  logic                 v0;
  logic signed [DW-1:0] d0   [3];
  logic signed [CB-1:0] eye0 [3];
  logic signed [CB-1:0] up0  [3];

  always_comb begin
    tgt_in[0] = target_x;
    tgt_in[1] = target_y;
    tgt_in[2] = target_z;
    eye_in[0] = eye_x;
    eye_in[1] = eye_y;
    eye_in[2] = eye_z;
    up_in[0]  = up_x;
    up_in[1]  = up_y;
    up_in[2]  = up_z;
    for (int i = 0; i < 3; i++) begin
      d_c[i] = DW'(tgt_in[i] >>> PRE) - DW'(eye_in[i] >>> PRE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0   <= d_c;
      eye0 <= eye_in;
      up0  <= up_in;
    end
  end

  // ---- up vector block scaling
  logic [S1W-1:0]       side_a;
  logic [S1W-1:0]       side_b;
  logic                 upsc_v;
  logic signed [SCW-1:0] upsc [3];
  logic signed [DW-1:0] d_b   [3];
  logic signed [CB-1:0] eye_b [3];

  assign side_a = {d0[0], d0[1], d0[2], eye0[0], eye0[1], eye0[2]};

  lav_scale #(
    .IW (CB),
    .SW (S1W)
  ) u_up_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v0),
    .src       (up0),
    .side_in   (side_a),
    .out_valid (upsc_v),
    .scaled    (upsc),
    .side_out  (side_b)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_b[i]   = $signed(side_b[S1W-1-i*DW -: DW]);
      eye_b[i] = $signed(side_b[3*CB-1-i*CB -: CB]);
    end
  end

  // ---- forward f
  logic [S2W-1:0]        side_a2;
  logic [S2W-1:0]        side_c;
  logic                  f_v;
  logic signed [OW-1:0]  f_c    [3];
  logic signed [SCW-1:0] upsc_c [3];
  logic signed [CB-1:0]  eye_c  [3];

  assign side_a2 = {upsc[0], upsc[1], upsc[2], eye_b[0], eye_b[1], eye_b[2]};

  lav_norm #(
    .IW (DW),
    .FB (FB),
    .SW (S2W)
  ) u_norm_fwd (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (upsc_v),
    .src       (d_b),
    .side_in   (side_a2),
    .out_valid (f_v),
    .unit_vec  (f_c),
    .side_out  (side_c)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      upsc_c[i] = $signed(side_c[S2W-1-i*SCW -: SCW]);
      eye_c[i]  = $signed(side_c[3*CB-1-i*CB -: CB]);
    end
  end

  // ---- f x up: products, then differences
  logic                  x1_v;
  logic signed [P1W-1:0] x1_p   [6];
  logic signed [OW-1:0]  x1_f   [3];
  logic signed [CB-1:0]  x1_eye [3];
  logic                  x2_v;
  logic signed [CW-1:0]  x2_c   [3];
  logic signed [OW-1:0]  x2_f   [3];
  logic signed [CB-1:0]  x2_eye [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_v <= 1'b0;
      x2_v <= 1'b0;
    end else if (adv) begin
      x1_v <= f_v;
      x2_v <= x1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_p[0] <= f_c[1] * upsc_c[2];
      x1_p[1] <= f_c[2] * upsc_c[1];
      x1_p[2] <= f_c[2] * upsc_c[0];
      x1_p[3] <= f_c[0] * upsc_c[2];
      x1_p[4] <= f_c[0] * upsc_c[1];
      x1_p[5] <= f_c[1] * upsc_c[0];
      x1_f    <= f_c;
      x1_eye  <= eye_c;
      for (int i = 0; i < 3; i++) begin
        x2_c[i] <= CW'(x1_p[2*i]) - CW'(x1_p[2*i+1]);
      end
      x2_f   <= x1_f;
      x2_eye <= x1_eye;
    end
  end

  // ---- side s
  logic [S3W-1:0]       side_a3;
  logic [S3W-1:0]       side_d;
  logic                 s_v;
  logic signed [OW-1:0] s_c   [3];
  logic signed [OW-1:0] f_d   [3];
  logic signed [CB-1:0] eye_d [3];

  assign side_a3 = {x2_f[0], x2_f[1], x2_f[2], x2_eye[0], x2_eye[1], x2_eye[2]};

  lav_norm #(
    .IW (CW),
    .FB (FB),
    .SW (S3W)
  ) u_norm_side (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (x2_v),
    .src       (x2_c),
    .side_in   (side_a3),
    .out_valid (s_v),
    .unit_vec  (s_c),
    .side_out  (side_d)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_d[i]   = $signed(side_d[S3W-1-i*OW -: OW]);
      eye_d[i] = $signed(side_d[3*CB-1-i*CB -: CB]);
    end
  end

  // ---- u = s x f, rounded and clamped
  logic                  y1_v;
  logic signed [P2W-1:0] y1_p   [6];
  logic signed [OW-1:0]  y1_s   [3];
  logic signed [OW-1:0]  y1_f   [3];
  logic signed [CB-1:0]  y1_eye [3];
  logic signed [AW-1:0]  a_c    [3];
  logic signed [AW-1:0]  ar_c   [3];
  logic signed [OW-1:0]  u_c    [3];
  logic                  y2_v;
  logic signed [OW-1:0]  y2_u   [3];
  logic signed [OW-1:0]  y2_s   [3];
  logic signed [OW-1:0]  y2_f   [3];
  logic signed [CB-1:0]  y2_eye [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_c[i]  = AW'(y1_p[2*i]) - AW'(y1_p[2*i+1]);
      ar_c[i] = (a_c[i] + HALF_A) >>> FB;
      if (ar_c[i] > UNIT_A) begin
        u_c[i] = UNIT_O;
      end else if (ar_c[i] < -UNIT_A) begin
        u_c[i] = -UNIT_O;
      end else begin
        u_c[i] = OW'(ar_c[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y1_v <= 1'b0;
      y2_v <= 1'b0;
    end else if (adv) begin
      y1_v <= s_v;
      y2_v <= y1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y1_p[0] <= s_c[1] * f_d[2];
      y1_p[1] <= s_c[2] * f_d[1];
      y1_p[2] <= s_c[2] * f_d[0];
      y1_p[3] <= s_c[0] * f_d[2];
      y1_p[4] <= s_c[0] * f_d[1];
      y1_p[5] <= s_c[1] * f_d[0];
      y1_s    <= s_c;
      y1_f    <= f_d;
      y1_eye  <= eye_d;
      y2_u    <= u_c;
      y2_s    <= y1_s;
      y2_f    <= y1_f;
      y2_eye  <= y1_eye;
    end
  end

  // ---- translations: weights -s, -u, f against eye
  logic signed [OW-1:0]  wt   [9];
  logic signed [PLW-1:0] lo_c [9];
  logic signed [PHW-1:0] hi_c [9];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wt[i]     = -y2_s[i];
      wt[3 + i] = -y2_u[i];
      wt[6 + i] = y2_f[i];
    end
  end

  if (CB > 32) begin : g_split
    // wide eye: low word unsigned, high word signed
    always_comb begin
      for (int m = 0; m < 9; m++) begin
        lo_c[m] = wt[m] * $signed({1'b0, y2_eye[m % 3][31:0]});
        hi_c[m] = wt[m] * $signed(y2_eye[m % 3][CB-1:32]);
      end
    end
  end else begin : g_single
    always_comb begin
      for (int m = 0; m < 9; m++) begin
        lo_c[m] = wt[m] * y2_eye[m % 3];
        hi_c[m] = '0;
      end
    end
  end

  logic                  z1_v;
  logic signed [PLW-1:0] z1_lo [9];
  logic signed [PHW-1:0] z1_hi [9];
  logic signed [OW-1:0]  z1_s  [3];
  logic signed [OW-1:0]  z1_u  [3];
  logic signed [OW-1:0]  z1_f  [3];
  logic signed [TW-1:0]  sum_c [3];
  logic                  z2_v;
  logic signed [TW-1:0]  z2_t  [3];
  logic signed [OW-1:0]  z2_s  [3];
  logic signed [OW-1:0]  z2_u  [3];
  logic signed [OW-1:0]  z2_f  [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_c[r] = '0;
      for (int n = 0; n < 3; n++) begin
        sum_c[r] = sum_c[r] + (TW'(z1_hi[3*r+n]) <<< 32) + TW'(z1_lo[3*r+n]);
      end
    end
  end

  // ---- result register
  logic signed [TW-1:0]  rt_c [3];
  logic signed [SHW-1:0] tr_c [3];
  logic signed [OW-1:0]  res_s  [3];
  logic signed [OW-1:0]  res_u  [3];
  logic signed [OW-1:0]  res_b  [3];
  logic signed [SHW-1:0] res_tr [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rt_c[r] = (z2_t[r] + HALF_T) >>> FB;
      if (rt_c[r] > SAT_HI) begin
        tr_c[r] = SHW'(SAT_HI);
      end else if (rt_c[r] < SAT_LO) begin
        tr_c[r] = SHW'(SAT_LO);
      end else begin
        tr_c[r] = SHW'(rt_c[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      z1_v  <= 1'b0;
      z2_v  <= 1'b0;
      res_v <= 1'b0;
    end else if (adv) begin
      z1_v  <= y2_v;
      z2_v  <= z1_v;
      res_v <= z2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z1_lo <= lo_c;
      z1_hi <= hi_c;
      z1_s  <= y2_s;
      z1_u  <= y2_u;
      z1_f  <= y2_f;
      z2_t  <= sum_c;
      z2_s  <= z1_s;
      z2_u  <= z1_u;
      z2_f  <= z1_f;
      res_s <= z2_s;
      res_u <= z2_u;
      for (int i = 0; i < 3; i++) begin
        res_b[i] <= -z2_f[i];
      end
      res_tr <= tr_c;
    end
  end

  assign side_x       = AXW'(res_s[0]);
  assign side_y       = AXW'(res_s[1]);
  assign side_z       = AXW'(res_s[2]);
  assign upward_x     = AXW'(res_u[0]);
  assign upward_y     = AXW'(res_u[1]);
  assign upward_z     = AXW'(res_u[2]);
  assign back_x       = AXW'(res_b[0]);
  assign back_y       = AXW'(res_b[1]);
  assign back_z       = AXW'(res_b[2]);
  assign shift_side   = res_tr[0];
  assign shift_upward = res_tr[1];
  assign shift_back   = res_tr[2];

`ifndef ASSERT_OFF
  a_side_unit: assert property (@(posedge clk) disable iff (rst)
    res_v |-> (res_s[0] <= UNIT_O) && (res_s[0] >= -UNIT_O) &&
              (res_s[1] <= UNIT_O) && (res_s[1] >= -UNIT_O) &&
              (res_s[2] <= UNIT_O) && (res_s[2] >= -UNIT_O))
    else $error("side component exceeds unit");

  a_up_unit: assert property (@(posedge clk) disable iff (rst)
    res_v |-> (res_u[0] <= UNIT_O) && (res_u[0] >= -UNIT_O) &&
              (res_u[1] <= UNIT_O) && (res_u[1] >= -UNIT_O) &&
              (res_u[2] <= UNIT_O) && (res_u[2] >= -UNIT_O))
    else $error("upward component exceeds unit");

  a_back_unit: assert property (@(posedge clk) disable iff (rst)
    res_v |-> (res_b[0] <= UNIT_O) && (res_b[0] >= -UNIT_O) &&
              (res_b[1] <= UNIT_O) && (res_b[1] >= -UNIT_O) &&
              (res_b[2] <= UNIT_O) && (res_b[2] >= -UNIT_O))
    else $error("back component exceeds unit");

  a_zero_fwd: assert property (@(posedge clk) disable iff (rst)
    res_v && (res_b[0] == '0) && (res_b[1] == '0) && (res_b[2] == '0) |->
      (res_s[0] == '0) && (res_s[1] == '0) && (res_s[2] == '0) &&
      (res_tr[0] == '0) && (res_tr[1] == '0) && (res_tr[2] == '0))
    else $error("zero forward did not zero the matrix");

  a_zero_side: assert property (@(posedge clk) disable iff (rst)
    res_v && (res_s[0] == '0) && (res_s[1] == '0) && (res_s[2] == '0) |->
      (res_u[0] == '0) && (res_u[1] == '0) && (res_u[2] == '0) &&
      (res_tr[0] == '0) && (res_tr[1] == '0))
    else $error("zero side did not zero upward row");
`endif

endmodule
